@@ design/elm_pkg.sv @@
// Package for the echoing line editor: line geometry, character codes,
// the command record passed from the front part to the back part.
// Depends on nothing.
package elm_pkg;

    localparam int MAX_LINE    = 32;
    localparam int STORE_DEPTH = MAX_LINE - 1;
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CHAR_W      = 7;
    localparam int BYTE_W      = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;

    localparam logic DEST_ECHO = 1'b0;
    localparam logic DEST_LINE = 1'b1;

    typedef enum logic [1:0] {
        CMD_ECHO,
        CMD_APPEND,
        CMD_ERASE,
        CMD_TERM
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [BYTE_W-1:0]   ch;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CR,
        BK_LF,
        BK_DATA
    } back_state_t;

endpackage

@@ design/elm_rx_if.sv @@
// Receive channel of the line editor: valid/ready and one received byte.
// Depends on elm_pkg.
interface elm_rx_if;
    import elm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

@@ design/elm_tx_if.sv @@
// Result channel of the line editor: valid/ready, destination, byte, last flag.
// Depends on elm_pkg.
interface elm_tx_if;
    import elm_pkg::*;

    logic              valid;
    logic              ready;
    logic              dest;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output dest, output out_byte, output last, input ready);
    modport sink   (input valid, input dest, input out_byte, input last, output ready);
endinterface

@@ design/elm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module elm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/elm_front.sv @@
// Front part of the line editor: accepts received bytes, classifies them
// into commands and holds them in a short queue. Depends on elm_pkg, elm_rx_if.
module elm_front (
    input  logic               clk,
    input  logic               rst_n,
    elm_rx_if.sink             rx,
    input  logic               pop,
    output elm_pkg::cmd_head_t head
);
    import elm_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              cmd_in;
    logic              push;

    always_comb
    begin
        cmd_in.ch = rx.rx_char;
        unique case (rx.rx_char) inside
            CHAR_CR, CHAR_LF:           cmd_in.kind = CMD_TERM;
            CHAR_BS, CHAR_DEL:          cmd_in.kind = CMD_ERASE;
            [CHAR_SPACE:CHAR_TILDE]:    cmd_in.kind = CMD_APPEND;
            default:                    cmd_in.kind = CMD_ECHO;
        endcase
    end

    assign rx.ready   = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = rx.valid && rx.ready;
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

@@ design/elm_back.sv @@
// Back part of the line editor: carries out queued commands, keeps the line
// store and length, and drives the result register. Depends on elm_pkg,
// elm_tx_if, elm_ram.
module elm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  elm_pkg::cmd_head_t head,
    output logic               pop,
    elm_tx_if.source           tx
);
    import elm_pkg::*;

    back_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_dest_reg, out_dest_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              slot_free;
    logic              we;
    logic [CHAR_W-1:0] rdata;
    logic              at_end;

    elm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (head.cmd.ch[CHAR_W-1:0]),
        .raddr (idx_next),
        .rdata (rdata)
    );

    assign slot_free = !out_valid_reg || tx.ready;
    assign at_end    = (LEN_W'(idx_reg) == LEN_W'(len_reg - LEN_W'(1)));

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !tx.ready;
        out_dest_next  = out_dest_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        we             = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid && slot_free)
                begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    out_dest_next  = DEST_ECHO;
                    out_byte_next  = head.cmd.ch;
                    out_last_next  = 1'b1;
                    unique case (head.cmd.kind)
                        CMD_APPEND:
                        begin
                            if (len_reg < LEN_W'(STORE_DEPTH))
                            begin
                                we       = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (len_reg != '0)
                            begin
                                len_next = len_reg - 1'b1;
                            end
                        end
                        CMD_TERM:
                        begin
                            if (len_reg != '0)
                            begin
                                out_last_next = 1'b0;
                                state_next    = BK_CR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_CR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_dest_next  = DEST_ECHO;
                    out_byte_next  = CHAR_CR;
                    out_last_next  = 1'b0;
                    state_next     = BK_LF;
                end
            end
            BK_LF:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_dest_next  = DEST_ECHO;
                    out_byte_next  = CHAR_LF;
                    out_last_next  = 1'b0;
                    idx_next       = '0;
                    state_next     = BK_DATA;
                end
            end
            BK_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_dest_next  = DEST_LINE;
                    out_byte_next  = {1'b0, rdata};
                    out_last_next  = at_end;
                    if (at_end)
                    begin
                        len_next   = '0;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dest_reg <= out_dest_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign tx.valid    = out_valid_reg;
    assign tx.dest     = out_dest_reg;
    assign tx.out_byte = out_byte_reg;
    assign tx.last     = out_last_reg;

endmodule

@@ design/echoing_line_editor_top.sv @@
// Echoing serial line editor: one received byte per transaction on rx; every
// byte is echoed on tx, printable bytes build a line of up to MAX_LINE-1
// characters, backspace and delete erase, and CR or LF on a non-empty line
// echoes CR LF and then delivers the line characters, the final result of
// each byte flagged by last. The back part emits one result per cycle while
// tx does not stall it, through a single output register; a two-entry
// command queue lets the receive side keep accepting while a line is
// delivered, until the queue is full.
// Depends on elm_pkg, elm_rx_if, elm_tx_if, elm_front, elm_back.
module echoing_line_editor_top (
    input  logic    clk,
    input  logic    rst_n,
    elm_rx_if.sink  rx,
    elm_tx_if.source tx
);
    import elm_pkg::*;

    cmd_head_t head;
    logic      pop;

    elm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .pop   (pop),
        .head  (head)
    );

    elm_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .tx    (tx)
    );

endmodule
